[hw/rtl/lsfs_pkg.sv]
`timescale 1ns / 1ps

package lsfs_pkg;

	localparam int FrameW = 32;
	localparam int IndexW = 8;
	localparam int ModeW  = 2;

	localparam logic [7:0] HdrMask = 8'hE0;
	localparam logic [FrameW-1:0] EndWord = 32'hFFFF_FFFF;
	localparam logic [FrameW-1:0] StartWord = 32'h0000_0000;

	typedef enum logic [ModeW-1:0] {
		MODE_SET    = 2'd0,
		MODE_SCROLL = 2'd1,
		MODE_SHOW   = 2'd2,
		MODE_INIT   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_FILL,
		CELL_SHIFT_UP,
		CELL_SHIFT_DN
	} cell_op_t;

	typedef struct packed {
		cell_op_t              op;
		logic [IndexW-1:0]     index;
		logic [FrameW-1:0]     frame;
	} cell_ctrl_t;

	localparam logic [0:0] REG_BRIGHTNESS = 1'b0;
	localparam logic [0:0] REG_GREY       = 1'b1;

	function automatic logic [FrameW-1:0] make_frame(
		input logic [7:0] bright,
		input logic [7:0] r,
		input logic [7:0] g,
		input logic [7:0] b
	);
		return {bright | HdrMask, b, g, r};
	endfunction

endpackage

[hw/rtl/lsfs_cell.sv]
`timescale 1ns / 1ps

module lsfs_cell #(
	parameter int IDX = 0
) (
	input  logic                       clk,
	input  lsfs_pkg::cell_ctrl_t       ctrl,
	input  logic [lsfs_pkg::FrameW-1:0] lo_frame,
	input  logic [lsfs_pkg::FrameW-1:0] hi_frame,
	output logic [lsfs_pkg::FrameW-1:0] frame
);
	import lsfs_pkg::*;

	localparam logic [IndexW-1:0] MyIndex = IndexW'(IDX);

	logic [FrameW-1:0] frame_q;

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			CELL_HOLD:     frame_q <= frame_q;
			CELL_LOAD:     if (ctrl.index == MyIndex) frame_q <= ctrl.frame;
			CELL_FILL:     frame_q <= ctrl.frame;
			CELL_SHIFT_UP: frame_q <= lo_frame;
			CELL_SHIFT_DN: frame_q <= hi_frame;
			default:       frame_q <= frame_q;
		endcase
	end

	assign frame = frame_q;

endmodule

[hw/rtl/led_strip_frame_store.sv]
`timescale 1ns / 1ps
// Channel   Dir  Beat content
// s_*       in   tuser = mode; tdata = led_index, red, green, blue
// m_*       out  tdata = frame_word; tlast = last_word
// APB       in   reg 0 brightness_byte @0x0, reg 1 grey_level @0x4
//
// Set and scroll act in ST_IDLE without leaving it. Show and init pass
// through ST_START, ST_FRAMES and ST_END, giving LED_COUNT + 2 output
// beats, one per cycle, gated by m_tready: the frame chain rotates one
// place per frame beat loaded. Input is accepted only between commands.
// Reset holds a zero fill on the frame chain, which runs once more at the
// first edge after release; registers reset to 255 and 32.
module led_strip_frame_store #(
	parameter int LED_COUNT = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // led_index[7:0], red[15:8], green[23:16], blue[31:24]
	input  logic [1:0]  s_tuser,   // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // frame_word[31:0]
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import lsfs_pkg::*;

	localparam int CntW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam logic [CntW-1:0] CntLast = CntW'(LED_COUNT - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_FRAMES,
		ST_END
	} state_t;

	state_t            state_q;
	logic [CntW-1:0]   cnt_q;
	logic [7:0]        bright_q;
	logic [7:0]        grey_q;
	logic              m_tvalid_q;
	logic [FrameW-1:0] m_tdata_q;
	logic              m_tlast_q;
	logic              slot;
	logic              cfg_wr;
	mode_t             mode;
	logic [FrameW-1:0] grey_frame;
	logic [FrameW-1:0] frame_w [LED_COUNT];
	logic              frames_zeroed_q;
	cell_ctrl_t        ctrl;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_GREY) ? {24'd0, grey_q} : {24'd0, bright_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q <= 8'd255;
			grey_q   <= 8'd32;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_GREY) grey_q <= pwdata[7:0];
			else bright_q <= pwdata[7:0];
		end
	end

	assign mode       = mode_t'(s_tuser);
	assign grey_frame = make_frame(bright_q, grey_q, grey_q, grey_q);
	assign slot       = !m_tvalid_q || m_tready;
	assign s_tready   = (state_q == ST_IDLE) && frames_zeroed_q;

	// until frames_zeroed_q is set every cell loads zero; then idle commands pick the op and frame beats shift down
	always_comb begin
		ctrl.op    = CELL_HOLD;
		ctrl.index = s_tdata[7:0];
		ctrl.frame = make_frame(bright_q, s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]);
		if (!frames_zeroed_q) begin
			ctrl.op    = CELL_FILL;
			ctrl.frame = '0;
		end else if (state_q == ST_IDLE && s_tvalid) begin
			unique case (mode)
				MODE_SET:    ctrl.op = CELL_LOAD;
				MODE_SCROLL: ctrl.op = CELL_SHIFT_UP;
				MODE_SHOW:   ctrl.op = CELL_HOLD;
				MODE_INIT: begin
					ctrl.op    = CELL_FILL;
					ctrl.frame = grey_frame;
				end
				default:     ctrl.op = CELL_HOLD;
			endcase
		end else if (state_q == ST_FRAMES && slot) begin
			ctrl.op = CELL_SHIFT_DN;
		end
	end

	for (genvar i = 0; i < LED_COUNT; i++) begin : g_cell
		logic [FrameW-1:0] lo_w;
		logic [FrameW-1:0] hi_w;
		if (i == 0) begin : g_lo_first
			assign lo_w = grey_frame;
		end else begin : g_lo_mid
			assign lo_w = frame_w[i-1];
		end
		if (i == LED_COUNT - 1) begin : g_hi_last
			assign hi_w = frame_w[0];
		end else begin : g_hi_mid
			assign hi_w = frame_w[i+1];
		end
		lsfs_cell #(.IDX(i)) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.lo_frame (lo_w),
			.hi_frame (hi_w),
			.frame    (frame_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			cnt_q           <= '0;
			m_tvalid_q      <= 1'b0;
			m_tdata_q       <= '0;
			m_tlast_q       <= 1'b0;
			frames_zeroed_q <= 1'b0;
		end else begin
			frames_zeroed_q <= 1'b1;
			m_tvalid_q      <= ((state_q != ST_IDLE) && slot) || (m_tvalid_q && !m_tready);
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid && s_tready && (mode == MODE_SHOW || mode == MODE_INIT))
						state_q <= ST_START;
				end
				ST_START: begin
					if (slot) begin
						m_tdata_q  <= StartWord;
						m_tlast_q  <= 1'b0;
						cnt_q      <= '0;
						state_q    <= ST_FRAMES;
					end
				end
				ST_FRAMES: begin
					if (slot) begin
						m_tdata_q  <= frame_w[0];
						m_tlast_q  <= 1'b0;
						cnt_q      <= cnt_q + 1'b1;
						if (cnt_q == CntLast) state_q <= ST_END;
					end
				end
				ST_END: begin
					if (slot) begin
						m_tdata_q  <= EndWord;
						m_tlast_q  <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

[hw/rtl/lsfs_checker.sv]
`timescale 1ns / 1ps

module lsfs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast
);
	import lsfs_pkg::*;

	// held beat stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat dropped while stalled");

	a_end_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata == EndWord)
		else $error("last beat is not the end word");

	a_show_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == MODE_SHOW || s_tuser == MODE_INIT) |=> !s_tready)
		else $error("input taken during a show");

	a_idle_stays: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready && !s_tvalid |=> s_tready)
		else $error("block left idle without a command");

endmodule

bind led_strip_frame_store lsfs_checker u_lsfs_checker (.*);
